FILE: design/scrolling_text_line_buffer_top_macros.svh
// ----------------------------------------------------------------------------
// Scrolling text line buffer assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef SCROLLING_TEXT_LINE_BUFFER_TOP_MACROS_SVH
`define SCROLLING_TEXT_LINE_BUFFER_TOP_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define STLB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define STLB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/stlb_pkg.sv
// ----------------------------------------------------------------------------
// Scrolling text line buffer package
// Sizes, codes and shared structures of the line buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stlb_pkg;

    localparam int MAX_COLUMNS = 128;
    localparam int MAX_ROWS    = 128;

    localparam int COL_AW    = $clog2(MAX_COLUMNS);
    localparam int ROW_AW    = $clog2(MAX_ROWS);
    localparam int STORE_AW  = ROW_AW + COL_AW;
    localparam int LEN_W     = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);

    localparam int IDX_W  = 7;
    localparam int CHAR_W = 8;
    localparam int CFG_W  = 8;

    localparam int ROW_CMP_W = ((ROW_CNT_W > IDX_W) ? ROW_CNT_W : IDX_W) + 1;
    localparam int COL_CMP_W = ((LEN_W > IDX_W) ? LEN_W : IDX_W) + 1;
    localparam int CFG_CMP_W = ((CFG_W > LEN_W) ? CFG_W : LEN_W) + 2;

    localparam int APB_DW    = 32;
    localparam int CFG_AW    = 3;
    localparam int REG_IDX_W = 1;

    localparam logic [REG_IDX_W-1:0] REG_COLUMNS = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_ROWS    = 1'b1;

    localparam logic [CFG_W-1:0] COLUMNS_RESET = 8'd80;
    localparam logic [CFG_W-1:0] ROWS_RESET    = 8'd100;

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'd0;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } t_op;

    // Effective sizes plus a one-cycle clear strobe on any register write.
    typedef struct packed {
        logic [LEN_W-1:0]     ncol;
        logic [ROW_CNT_W-1:0] nrow;
        logic                 clear;
    } t_cfg;

    // Memory requests for the current item.
    typedef struct packed {
        logic                rd;
        logic                rd_hit;
        logic                char_en;
        logic                char_we;
        logic [STORE_AW-1:0] char_addr;
        logic [CHAR_W-1:0]   char_wdata;
        logic                len_en;
        logic                len_we;
        logic [ROW_AW-1:0]   len_addr;
        logic [LEN_W-1:0]    len_wdata;
    } t_mem_req;

endpackage

`default_nettype wire

FILE: design/stlb_ram.sv
// ----------------------------------------------------------------------------
// Line buffer single-port RAM
// One access a cycle, read data registered and held until the next read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stlb_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 14
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [DATA_W-1:0] i_wdata,
    output      logic [DATA_W-1:0] o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/stlb_cfg.sv
// ----------------------------------------------------------------------------
// Line buffer configuration registers
// APB-style size registers, clamped sizes and the store clear strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stlb_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [stlb_pkg::CFG_AW-1:0]   paddr,
    input  wire logic [stlb_pkg::APB_DW-1:0]   pwdata,
    output      logic [stlb_pkg::APB_DW-1:0]   prdata,
    output      logic                          pready,
    output      stlb_pkg::t_cfg                o_cfg
);

    import stlb_pkg::*;

    logic [CFG_W-1:0]     r_columns;
    logic [CFG_W-1:0]     r_rows;
    logic [CFG_W-1:0]     n_columns;
    logic [CFG_W-1:0]     n_rows;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_strobe;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[CFG_AW-1:2];
    assign wr_strobe = psel && penable && pwrite && pready;

    always_comb begin
        n_columns = r_columns;
        n_rows    = r_rows;
        prdata    = '0;
        unique case (reg_idx)
            REG_COLUMNS: begin
                prdata = APB_DW'(r_columns);
                if (wr_strobe) begin
                    n_columns = pwdata[CFG_W-1:0];
                end
            end
            REG_ROWS: begin
                prdata = APB_DW'(r_rows);
                if (wr_strobe) begin
                    n_rows = pwdata[CFG_W-1:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= COLUMNS_RESET;
            r_rows    <= ROWS_RESET;
        end else begin
            r_columns <= n_columns;
            r_rows    <= n_rows;
        end
    end

    // Clamp oversized settings to the physical store.
    always_comb begin
        o_cfg.ncol  = (CFG_CMP_W'(r_columns) > CFG_CMP_W'(MAX_COLUMNS))
                    ? LEN_W'(MAX_COLUMNS) : LEN_W'(r_columns);
        o_cfg.nrow  = (CFG_CMP_W'(r_rows) > CFG_CMP_W'(MAX_ROWS))
                    ? ROW_CNT_W'(MAX_ROWS) : ROW_CNT_W'(r_rows);
        o_cfg.clear = wr_strobe;
    end

endmodule

`default_nettype wire

FILE: design/stlb_ctrl.sv
// ----------------------------------------------------------------------------
// Line buffer access control
// Ring pointer, cursor and row valid bits; memory requests for each item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stlb_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire stlb_pkg::t_cfg                i_cfg,
    input  wire logic                          i_accept,
    input  wire logic                          i_operation,
    input  wire logic                          i_new_message,
    input  wire logic [stlb_pkg::CHAR_W-1:0]   i_char_code,
    input  wire logic [stlb_pkg::IDX_W-1:0]    i_row_index,
    input  wire logic [stlb_pkg::IDX_W-1:0]    i_column_index,
    output      stlb_pkg::t_mem_req            o_req
);

    import stlb_pkg::*;

    logic [ROW_AW-1:0]    r_ptr;
    logic [ROW_AW-1:0]    n_ptr;
    logic [LEN_W-1:0]     r_cursor;
    logic [LEN_W-1:0]     n_cursor;
    logic [MAX_ROWS-1:0]  r_row_valid;
    logic [MAX_ROWS-1:0]  n_row_valid;

    logic                 sized;
    logic                 rd_acc;
    logic                 wr_acc;
    logic                 wr_char;
    logic [LEN_W-1:0]     cur;
    logic                 scroll;
    logic [ROW_AW-1:0]    wr_row;
    logic [COL_AW-1:0]    wr_col;
    logic [LEN_W-1:0]     new_len;
    logic [ROW_CMP_W-1:0] row_sum;
    logic [ROW_CMP_W-1:0] row_phys;
    logic [ROW_AW-1:0]    rd_row;
    logic [COL_AW-1:0]    rd_col;
    logic                 rd_in_range;

    assign sized  = (i_cfg.ncol != '0) && (i_cfg.nrow != '0);
    assign rd_acc = i_accept && (i_operation == OP_READ);
    assign wr_acc = i_accept && (i_operation == OP_WRITE) && sized;

    // Write side: new-message forces column 0, which then scrolls.
    assign cur     = i_new_message ? '0 : r_cursor;
    assign wr_char = (i_char_code != CHAR_NEWLINE) && (i_char_code != CHAR_NUL);
    assign scroll  = (cur == '0) || (cur >= i_cfg.ncol);

    always_comb begin
        if (!scroll) begin
            wr_row = r_ptr;
        end else if (r_ptr == '0) begin
            wr_row = ROW_AW'(i_cfg.nrow - ROW_CNT_W'(1));
        end else begin
            wr_row = r_ptr - ROW_AW'(1);
        end
    end

    assign wr_col  = scroll ? '0 : COL_AW'(cur);
    assign new_len = LEN_W'(wr_col) + LEN_W'(1);

    // Read side: logical row to ring slot, one compare and subtract.
    assign row_sum  = ROW_CMP_W'(r_ptr) + ROW_CMP_W'(i_row_index);
    assign row_phys = (row_sum >= ROW_CMP_W'(i_cfg.nrow))
                    ? row_sum - ROW_CMP_W'(i_cfg.nrow) : row_sum;
    assign rd_row   = ROW_AW'(row_phys);
    assign rd_col   = COL_AW'(i_column_index);

    assign rd_in_range = sized
        && (ROW_CMP_W'(i_row_index) < ROW_CMP_W'(i_cfg.nrow))
        && (COL_CMP_W'(i_column_index) < COL_CMP_W'(i_cfg.ncol));

    always_comb begin
        n_ptr       = r_ptr;
        n_cursor    = r_cursor;
        n_row_valid = r_row_valid;
        if (i_cfg.clear) begin
            n_ptr       = '0;
            n_cursor    = '0;
            n_row_valid = '0;
        end else if (wr_acc) begin
            if (i_char_code == CHAR_NEWLINE) begin
                n_cursor = '0;
            end else if (wr_char) begin
                n_ptr               = wr_row;
                n_cursor            = new_len;
                n_row_valid[wr_row] = 1'b1;
            end else begin
                n_cursor = cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_cursor    <= '0;
            r_row_valid <= '0;
        end else begin
            r_ptr       <= n_ptr;
            r_cursor    <= n_cursor;
            r_row_valid <= n_row_valid;
        end
    end

    always_comb begin
        o_req.rd         = rd_acc;
        o_req.rd_hit     = rd_in_range && r_row_valid[rd_row];
        o_req.char_we    = wr_acc && wr_char;
        o_req.char_en    = rd_acc || o_req.char_we;
        o_req.char_addr  = o_req.char_we ? {wr_row, wr_col} : {rd_row, rd_col};
        o_req.char_wdata = i_char_code;
        o_req.len_we     = o_req.char_we;
        o_req.len_en     = o_req.char_en;
        o_req.len_addr   = o_req.char_we ? wr_row : rd_row;
        o_req.len_wdata  = new_len;
    end

endmodule

`default_nettype wire

FILE: design/scrolling_text_line_buffer_top.sv
// ----------------------------------------------------------------------------
// Scrolling text line buffer
// Character store of a scrolling console, addressed by a ring of rows.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  --------  --------------------  ---------------------------------------------
//  request   i_valid / o_stall     i_operation, i_new_message, i_char_code,
//                                  i_row_index, i_column_index
//  result    o_valid / i_stall     o_cell_char (reads only)
//  config    psel/penable/pwrite   paddr, pwdata, prdata (columns at 0, rows at 4)
//
//  One request per cycle while o_stall is low, reads and writes alike: each
//  takes at most a single access to the character RAM and the row length RAM.
//  A read result is registered in the read stage, then in the output register.
//  Synchronous active-low reset; row valid flops clear at once, so there is
//  no clearing pass. A register write clears the same way.
//  o_stall rises only while a read waits behind a stalled result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scrolling_text_line_buffer_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          i_valid,
    output      logic                          o_stall,
    input  wire logic                          i_operation,
    input  wire logic                          i_new_message,
    input  wire logic [stlb_pkg::CHAR_W-1:0]   i_char_code,
    input  wire logic [stlb_pkg::IDX_W-1:0]    i_row_index,
    input  wire logic [stlb_pkg::IDX_W-1:0]    i_column_index,
    // result channel
    output      logic                          o_valid,
    input  wire logic                          i_stall,
    output      logic [stlb_pkg::CHAR_W-1:0]   o_cell_char,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [stlb_pkg::CFG_AW-1:0]   paddr,
    input  wire logic [stlb_pkg::APB_DW-1:0]   pwdata,
    output      logic [stlb_pkg::APB_DW-1:0]   prdata,
    output      logic                          pready
);

    import stlb_pkg::*;

    t_cfg              cfg;
    t_mem_req          req;
    logic              in_accept;
    logic              s1_adv;
    logic [CHAR_W-1:0] char_rdata;
    logic [LEN_W-1:0]  len_rdata;
    logic [CHAR_W-1:0] cell_value;

    // Read stage: memory data is in flight, hit flag and column ride along.
    logic              r_s1_valid;
    logic              r_s1_hit;
    logic [IDX_W-1:0]  r_s1_cix;
    // Output register.
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;

    stlb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Hold the request side only while a read waits behind a stalled result.
    assign s1_adv    = !r_out_valid || !i_stall;
    assign o_stall   = r_s1_valid && !s1_adv;
    assign in_accept = i_valid && !o_stall;

    stlb_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_accept       (in_accept),
        .i_operation    (i_operation),
        .i_new_message  (i_new_message),
        .i_char_code    (i_char_code),
        .i_row_index    (i_row_index),
        .i_column_index (i_column_index),
        .o_req          (req)
    );

    stlb_ram #(
        .DATA_W (CHAR_W),
        .ADDR_W (STORE_AW)
    ) u_char_ram (
        .i_clk   (i_clk),
        .i_en    (req.char_en),
        .i_we    (req.char_we),
        .i_addr  (req.char_addr),
        .i_wdata (req.char_wdata),
        .o_rdata (char_rdata)
    );

    stlb_ram #(
        .DATA_W (LEN_W),
        .ADDR_W (ROW_AW)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_en    (req.len_en),
        .i_we    (req.len_we),
        .i_addr  (req.len_addr),
        .i_wdata (req.len_wdata),
        .o_rdata (len_rdata)
    );

    // Advance the read stage; writes leave it alone since they give no result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (req.rd) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req.rd) begin
            r_s1_hit <= req.rd_hit;
            r_s1_cix <= i_column_index;
        end
    end

    // Gate the cell by the row length: past the end of the row reads as empty.
    assign cell_value = (r_s1_hit && (COL_CMP_W'(r_s1_cix) < COL_CMP_W'(len_rdata)))
                      ? char_rdata : CHAR_NUL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s1_valid && s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_adv) begin
            r_out_char <= cell_value;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_cell_char = r_out_char;

`include "scrolling_text_line_buffer_top_macros.svh"

    // A result only ever comes from a read that was in the read stage.
    `STLB_ASSERT_SAME(a_out_from_read, $rose(o_valid), $past(r_s1_valid), "result without a read")
    // Back-pressure only while a read is blocked by a stalled result.
    `STLB_ASSERT_SAME(a_stall_cause, o_stall, r_s1_valid && o_valid && i_stall, "stall without cause")
    // An accepted write never occupies the read stage.
    `STLB_ASSERT_NEXT(a_write_no_result, in_accept && (i_operation == OP_WRITE), !r_s1_valid, "write entered read stage")
    // An accepted read always occupies the read stage next cycle.
    `STLB_ASSERT_NEXT(a_read_tracked, in_accept && (i_operation == OP_READ), r_s1_valid, "read lost")

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// Scrolling text line buffer testbench
// Drives character and cell-read requests with random idle gaps and output
// stalls, predicts every read from a shadow copy of the ring of rows, and
// sweeps the column and row registers through small, full, zero and
// oversized settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import stlb_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int IDLE_PCT      = 18;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int SWEEP_PHASES  = 12;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_SHOWN     = 10;

    // One request as it crosses the request channel.
    typedef struct {
        t_op               op;
        logic              new_msg;
        logic [CHAR_W-1:0] char_code;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
    } t_console_req;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_operation;
    logic                  i_new_message;
    logic [CHAR_W-1:0]     i_char_code;
    logic [IDX_W-1:0]      i_row_index;
    logic [IDX_W-1:0]      i_column_index;
    logic                  o_valid;
    logic                  i_stall;
    logic [CHAR_W-1:0]     o_cell_char;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    scrolling_text_line_buffer_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_new_message  (i_new_message),
        .i_char_code    (i_char_code),
        .i_row_index    (i_row_index),
        .i_column_index (i_column_index),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_cell_char    (o_cell_char),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Shadow of the console: physical rows, their lengths, ring head, cursor.
    logic [CHAR_W-1:0] shadow_cells [MAX_ROWS][MAX_COLUMNS];
    int unsigned       shadow_len [MAX_ROWS];
    int unsigned       shadow_newest;
    int unsigned       shadow_cursor;
    logic [CFG_W-1:0]  shadow_columns;
    logic [CFG_W-1:0]  shadow_rows;

    // Cell bytes still owed by the block, oldest read first.
    logic [CHAR_W-1:0] expected_cells [$];
    logic [CHAR_W-1:0] oldest_cell;

    int unsigned fail_count;
    int unsigned shown_count;
    int unsigned cycle_count;
    bit          steady_traffic;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------

    // Clip the registers to the store's real size.
    function automatic int unsigned active_columns();
        return (shadow_columns > MAX_COLUMNS) ? MAX_COLUMNS : shadow_columns;
    endfunction

    function automatic int unsigned active_rows();
        return (shadow_rows > MAX_ROWS) ? MAX_ROWS : shadow_rows;
    endfunction

    // Drop every row: old cells stay in memory but can no longer be reached.
    function automatic void clear_shadow();
        foreach (shadow_len[i]) shadow_len[i] = 0;
        shadow_newest = 0;
        shadow_cursor = 0;
    endfunction

    function automatic void apply_register(logic [REG_IDX_W-1:0] idx,
                                           logic [CFG_W-1:0] value);
        if (idx == REG_COLUMNS) begin
            shadow_columns = value;
        end else begin
            shadow_rows = value;
        end
        clear_shadow();
    endfunction

    // Advance the shadow by one accepted request; queue the byte a read owes.
    function automatic void predict_console(t_console_req req);
        int unsigned       ncol;
        int unsigned       nrow;
        int unsigned       phys;
        logic [CHAR_W-1:0] cell_byte;
        ncol = active_columns();
        nrow = active_rows();
        if (req.op == OP_READ) begin
            cell_byte = CHAR_NUL;
            if (ncol != 0 && nrow != 0 && req.row < nrow && req.col < ncol) begin
                phys = (shadow_newest + req.row) % nrow;
                if (req.col < shadow_len[phys]) begin
                    cell_byte = shadow_cells[phys][req.col];
                end
            end
            expected_cells.push_back(cell_byte);
        end else if (ncol != 0 && nrow != 0) begin
            // A new message restarts the line even for newline and NUL.
            if (req.new_msg) begin
                shadow_cursor = 0;
            end
            if (req.char_code == CHAR_NEWLINE) begin
                shadow_cursor = 0;
            end else if (req.char_code != CHAR_NUL) begin
                // Open a fresh newest row: step the ring head back, drop the oldest.
                if (shadow_cursor == 0 || shadow_cursor >= ncol) begin
                    shadow_newest = (shadow_newest + nrow - 1) % nrow;
                    shadow_len[shadow_newest] = 0;
                    shadow_cursor = 0;
                end
                shadow_cells[shadow_newest][shadow_cursor] = req.char_code;
                shadow_cursor++;
                shadow_len[shadow_newest] = shadow_cursor;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Hold the request until accepted, then maybe leave a short idle gap.
    // Called and returns at a falling edge; valid stays high when no gap.
    task automatic send_request(t_console_req req);
        i_valid        <= 1'b1;
        i_operation    <= req.op;
        i_new_message  <= req.new_msg;
        i_char_code    <= req.char_code;
        i_row_index    <= req.row;
        i_column_index <= req.col;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_console(req);
        @(negedge i_clk);
        if (!steady_traffic && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
    endtask

    // Drop valid, wait out every owed result, then let writes settle.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_cells.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic t_console_req char_item(logic new_msg, logic [CHAR_W-1:0] code);
        t_console_req req;
        req.op        = OP_WRITE;
        req.new_msg   = new_msg;
        req.char_code = code;
        req.row       = '0;
        req.col       = '0;
        return req;
    endfunction

    function automatic t_console_req read_item(int unsigned row, int unsigned col);
        t_console_req req;
        req.op        = OP_READ;
        req.new_msg   = 1'b0;
        req.char_code = CHAR_NUL;
        req.row       = IDX_W'(row);
        req.col       = IDX_W'(col);
        return req;
    endfunction

    // Mostly text with the odd newline, plus reads aimed at live cells;
    // the rest is raw noise. Unused fields carry random bits throughout.
    function automatic t_console_req make_console_request();
        t_console_req req;
        int unsigned  pick;
        int unsigned  ncol;
        int unsigned  nrow;
        int unsigned  span;
        int unsigned  len;
        req.op        = OP_WRITE;
        req.new_msg   = 1'($urandom_range(0, 1));
        req.char_code = CHAR_W'($urandom_range(0, 255));
        req.row       = IDX_W'($urandom_range(0, 127));
        req.col       = IDX_W'($urandom_range(0, 127));
        ncol = active_columns();
        nrow = active_rows();
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            req.char_code = CHAR_W'($urandom_range(33, 126));
            req.new_msg   = ($urandom_range(0, 99) < 6);
        end else if (pick < 53) begin
            req.char_code = CHAR_NEWLINE;
            req.new_msg   = ($urandom_range(0, 99) < 10);
        end else if (pick < 57) begin
            req.char_code = CHAR_NUL;
        end else if (pick >= 62) begin
            req.op = OP_READ;
            if (pick < 90 && ncol != 0 && nrow != 0) begin
                // Favor the newest rows so tall settings still hit text.
                span = nrow - 1;
                if (span > 12 && $urandom_range(0, 99) < 70) begin
                    span = 12;
                end
                req.row = IDX_W'($urandom_range(0, span));
                len     = shadow_len[(shadow_newest + req.row) % nrow];
                req.col = IDX_W'($urandom_range(0, (len < 127) ? len : 127));
            end
        end
        return req;
    endfunction

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------

    // Setup cycle, then access cycle; the register takes the value at the
    // access edge. The bus then idles so psel never toggles in a step.
    task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] data);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({idx, 2'b00});
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        apply_register(idx, data[CFG_W-1:0]);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic check_register(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CFG_AW'({idx, 2'b00});
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== APB_DW'(value)) begin
            note_failure("register readback", APB_DW'(value), prdata);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic note_failure(string what, logic [APB_DW-1:0] want, logic [APB_DW-1:0] got);
        fail_count++;
        if (shown_count < MAX_SHOWN) begin
            shown_count++;
            $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
        end
    endtask

    // Compare each accepted result with the oldest owed byte.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_cells.size() == 0) begin
                note_failure("result with no pending read", '0, APB_DW'(o_cell_char));
            end else begin
                oldest_cell = expected_cells.pop_front();
                if (o_cell_char !== oldest_cell) begin
                    note_failure("cell_char", APB_DW'(oldest_cell), APB_DW'(o_cell_char));
                end
            end
        end
    end

    // Stall results at random, except during the steady stretch.
    always @(negedge i_clk) begin
        i_stall <= !steady_traffic && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Give up on a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values read back, and upper data bits beyond the register drop.
    task automatic test_register_readback();
        check_register(REG_COLUMNS, COLUMNS_RESET);
        check_register(REG_ROWS, ROWS_RESET);
        write_register(REG_COLUMNS, 32'hABCD_EF05);
        check_register(REG_COLUMNS, 8'd5);
        write_register(REG_ROWS, 32'd3);
        check_register(REG_ROWS, 8'd3);
    endtask

    // Four columns, three rows: wrap on a full row, newline, NUL, new-message
    // restarts, dropping the oldest row, byte extremes and out-of-range reads.
    task automatic test_directed_cases();
        write_register(REG_COLUMNS, 32'd4);
        write_register(REG_ROWS, 32'd3);
        send_request(char_item(1'b1, "A"));
        send_request(char_item(1'b0, "B"));
        send_request(char_item(1'b0, "C"));
        send_request(char_item(1'b0, "D"));
        send_request(char_item(1'b0, "E"));
        send_request(char_item(1'b0, CHAR_NEWLINE));
        send_request(char_item(1'b0, CHAR_NUL));
        send_request(char_item(1'b0, "F"));
        send_request(char_item(1'b1, CHAR_NUL));
        send_request(char_item(1'b0, "G"));
        send_request(char_item(1'b1, CHAR_NEWLINE));
        send_request(char_item(1'b0, 8'hFF));
        send_request(char_item(1'b0, 8'h01));
        send_request(read_item(0, 0));
        send_request(read_item(0, 1));
        send_request(read_item(0, 2));
        send_request(read_item(1, 0));
        send_request(read_item(2, 0));
        send_request(read_item(3, 0));
        send_request(read_item(0, 4));
        send_request(read_item(127, 127));
    endtask

    // Random traffic under many sizes: the smallest, the largest, zero and
    // oversized values. Halfway through each phase drain the results and
    // rewrite one register to clear the store with text in it.
    task automatic test_size_sweep();
        int unsigned sweep_cols [SWEEP_PHASES];
        int unsigned sweep_rows [SWEEP_PHASES];
        int unsigned per_phase;
        sweep_cols = '{5, 1, 128, 0, 6, 200, 3, 8, 128, 12, 0, 0};
        sweep_rows = '{3, 1, 128, 4, 0, 255, 2, 128, 2, 7, 0, 0};
        sweep_cols[10] = $urandom_range(1, 16);
        sweep_rows[10] = $urandom_range(1, 10);
        sweep_cols[11] = $urandom_range(1, 40);
        sweep_rows[11] = $urandom_range(2, 20);
        per_phase = RANDOM_ITEMS / SWEEP_PHASES;
        for (int p = 0; p < SWEEP_PHASES; p++) begin
            write_register(REG_COLUMNS, APB_DW'(sweep_cols[p]));
            write_register(REG_ROWS, APB_DW'(sweep_rows[p]));
            steady_traffic = (p == 6);
            for (int n = 0; n < per_phase; n++) begin
                if (n == per_phase / 2) begin
                    if (p % 2 == 1) begin
                        write_register(REG_ROWS, APB_DW'(sweep_rows[p]));
                    end else begin
                        write_register(REG_COLUMNS, APB_DW'(sweep_cols[p]));
                    end
                end
                send_request(make_console_request());
            end
            steady_traffic = 1'b0;
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_operation    = OP_WRITE;
        i_new_message  = 1'b0;
        i_char_code    = CHAR_NUL;
        i_row_index    = '0;
        i_column_index = '0;
        i_stall        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        fail_count     = 0;
        shown_count    = 0;
        cycle_count    = 0;
        steady_traffic = 1'b0;
        shadow_columns = COLUMNS_RESET;
        shadow_rows    = ROWS_RESET;
        clear_shadow();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_register_readback();
        test_directed_cases();
        test_size_sweep();

        // Stop sending, collect what is still owed, let the pipe empty.
        drain_results();
        fail_count += expected_cells.size();
        if (fail_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
